// File: rtl/core/swdh_pkg.sv
// swdh_pkg: shared types and constants of the serial wire debug host engine
// no dependencies; imported by every module under rtl/core
package swdh_pkg;

  localparam int LINE_RESET_CLOCKS = 56;
  localparam int BC_W              = 6;
  localparam logic [BC_W-1:0] LAST_LR = BC_W'(LINE_RESET_CLOCKS - 1);

  localparam logic [15:0] SWITCH_SEQ   = 16'hE79E;
  localparam logic [7:0]  REQ_FIXED    = 8'h81;
  localparam logic [7:0]  RETRY_RESET  = 8'd64;

  localparam int PADDR_W = 3;

  // command codes
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_XFER    = 2'd1;
  localparam logic [1:0] CMD_LINE_RST = 2'd2;
  localparam logic [1:0] CMD_CONNECT = 2'd3;

  // acknowledge codes
  localparam logic [2:0] ACK_OK    = 3'd1;
  localparam logic [2:0] ACK_WAIT  = 3'd2;
  localparam logic [2:0] ACK_FAULT = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FAULT    = 3'd1;
  localparam logic [2:0] ST_PROTOCOL = 3'd2;
  localparam logic [2:0] ST_PARITY   = 3'd3;
  localparam logic [2:0] ST_TIMEOUT  = 3'd4;

  // register indexes
  localparam logic [PADDR_W-1:0] ADDR_RETRY_LIMIT = PADDR_W'(0);

  typedef struct packed {
    logic [1:0]  cmd;
    logic        ap_not_dp;
    logic        read_not_write;
    logic [1:0]  reg_addr;
    logic [31:0] write_data;
    logic        swdio_in;
  } item_t;

  typedef struct packed {
    logic        swdio_out;
    logic        swdio_drive;
    logic        clock_pulse;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  status;
    logic [31:0] read_data;
  } result_t;

endpackage

// File: rtl/core/swdh_apb_regs.sv
// swdh_apb_regs: apb configuration register (wait retry limit)
// depends on swdh_pkg
module swdh_apb_regs
  import swdh_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [7:0]         retry_limit_o
);

  logic [7:0] retry_limit_q;
  logic [7:0] retry_limit_d;
  logic       hit;

  // low address bits are byte lanes within the word
  assign hit = (paddr[PADDR_W-1:2] == ADDR_RETRY_LIMIT[PADDR_W-1:2]);

  always_comb begin
    retry_limit_d = retry_limit_q;
    if (psel && penable && pwrite && hit) begin
      retry_limit_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= RETRY_RESET;
    end else begin
      retry_limit_q <= retry_limit_d;
    end
  end

  assign prdata        = hit ? {24'd0, retry_limit_q} : 32'd0;
  assign pready        = 1'b1;
  assign retry_limit_o = retry_limit_q;

endmodule

// File: rtl/core/swdh_engine.sv
// swdh_engine: swd bit-period sequencer, one transaction per step, with result register
// depends on swdh_pkg
module swdh_engine
  import swdh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  item_t      item_i,
  input  logic [7:0] retry_limit_i,
  output result_t    res_o
);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_REQ    = 4'd1,
    PH_TRNA   = 4'd2,
    PH_ACK    = 4'd3,
    PH_TRNEND = 4'd4,
    PH_RDATA  = 4'd5,
    PH_TRNW   = 4'd6,
    PH_WDATA  = 4'd7,
    PH_LRH    = 4'd8,
    PH_LRL    = 4'd9,
    PH_C1H    = 4'd10,
    PH_C1L    = 4'd11,
    PH_CSW    = 4'd12,
    PH_C2H    = 4'd13,
    PH_C2L    = 4'd14
  } phase_e;

  phase_e          phase_q, phase_d, ph_cur, ph_start;
  logic [BC_W-1:0] bc_q, bc_d, bc_cur;
  logic [31:0]     shift_q, shift_d, shift_cur;
  logic [7:0]      req_q, req_d, req_cur, req_new;
  logic [2:0]      ack_q, ack_d;
  logic [7:0]      att_q, att_d, att_cur, att_inc, lim;
  logic            rflag_q, rflag_d, rflag_cur;
  logic            drive_q, drive_d;
  logic            starting, is_idle, req_par;
  result_t         res_q, res_d;

  assign is_idle  = (phase_q == PH_IDLE);
  assign starting = is_idle && (item_i.cmd == CMD_XFER);
  assign lim      = (retry_limit_i == 8'd0) ? 8'd1 : retry_limit_i;
  assign req_par  = item_i.ap_not_dp ^ item_i.read_not_write ^ item_i.reg_addr[0]
                  ^ item_i.reg_addr[1];
  assign req_new  = REQ_FIXED | {2'b00, req_par, item_i.reg_addr[1], item_i.reg_addr[0],
                                 item_i.read_not_write, item_i.ap_not_dp, 1'b0};
  assign att_inc  = att_cur + 8'd1;

  always_comb begin
    case (item_i.cmd)
      CMD_XFER:     ph_start = PH_REQ;
      CMD_LINE_RST: ph_start = PH_LRH;
      CMD_CONNECT:  ph_start = PH_C1H;
      default:      ph_start = PH_IDLE;
    endcase
  end

  // a command starts in the bit period in which it arrives
  assign ph_cur    = is_idle ? ph_start : phase_q;
  assign bc_cur    = is_idle ? '0 : bc_q;
  assign req_cur   = starting ? req_new : req_q;
  assign shift_cur = starting ? item_i.write_data : shift_q;
  assign rflag_cur = starting ? item_i.read_not_write : rflag_q;
  assign att_cur   = starting ? 8'd0 : att_q;

  always_comb begin
    phase_d = ph_cur;
    bc_d    = bc_cur;
    shift_d = shift_cur;
    req_d   = req_cur;
    ack_d   = ack_q;
    att_d   = att_cur;
    rflag_d = rflag_cur;
    drive_d = drive_q;
    res_d             = '0;
    res_d.swdio_drive = drive_q;
    res_d.status      = ST_OK;

    if (ph_cur != PH_IDLE) begin
      res_d.clock_pulse = 1'b1;
      res_d.swdio_drive = 1'b1;
      case (ph_cur)
        PH_REQ: begin
          res_d.swdio_out = req_cur[bc_cur[2:0]];
          if (bc_cur >= BC_W'(7)) begin
            phase_d = PH_TRNA;
            bc_d    = '0;
          end else begin
            bc_d = bc_cur + 1'b1;
          end
        end
        PH_TRNA: begin
          res_d.swdio_drive = 1'b0;
          phase_d = PH_ACK;
          bc_d    = '0;
          ack_d   = '0;
        end
        PH_ACK: begin
          res_d.swdio_drive = 1'b0;
          ack_d = ack_q | (3'(item_i.swdio_in) << bc_cur[1:0]);
          if (bc_cur >= BC_W'(2)) begin
            bc_d = '0;
            if (ack_d == ACK_OK) begin
              if (rflag_cur) begin
                phase_d = PH_RDATA;
                shift_d = '0;
              end else begin
                phase_d = PH_TRNW;
              end
            end else begin
              phase_d = PH_TRNEND;
            end
          end else begin
            bc_d = bc_cur + 1'b1;
          end
        end
        PH_TRNEND: begin
          res_d.swdio_drive = 1'b0;
          phase_d = PH_IDLE;
          if (ack_q == ACK_OK) begin
            // after a read, the flag holds the parity mismatch
            res_d.done_res  = 1'b1;
            res_d.status    = rflag_cur ? ST_PARITY : ST_OK;
            res_d.read_data = rflag_cur ? 32'd0 : shift_cur;
          end else if (ack_q == ACK_WAIT) begin
            att_d = att_inc;
            if (att_inc >= lim) begin
              res_d.done_res = 1'b1;
              res_d.status   = ST_TIMEOUT;
            end else begin
              phase_d = PH_REQ;
              bc_d    = '0;
            end
          end else begin
            res_d.done_res = 1'b1;
            res_d.status   = (ack_q == ACK_FAULT) ? ST_FAULT : ST_PROTOCOL;
          end
        end
        PH_RDATA: begin
          res_d.swdio_drive = 1'b0;
          if (!bc_cur[5]) begin
            shift_d[bc_cur[4:0]] = shift_cur[bc_cur[4:0]] | item_i.swdio_in;
            bc_d = bc_cur + 1'b1;
          end else begin
            rflag_d = item_i.swdio_in ^ (^shift_cur);
            phase_d = PH_TRNEND;
            bc_d    = '0;
          end
        end
        PH_TRNW: begin
          res_d.swdio_drive = 1'b0;
          phase_d = PH_WDATA;
          bc_d    = '0;
        end
        PH_WDATA: begin
          if (!bc_cur[5]) begin
            res_d.swdio_out = shift_cur[bc_cur[4:0]];
            bc_d = bc_cur + 1'b1;
          end else begin
            res_d.swdio_out = ^shift_cur;
            res_d.done_res  = 1'b1;
            phase_d = PH_IDLE;
            bc_d    = '0;
          end
        end
        PH_LRH, PH_C1H, PH_C2H: begin
          res_d.swdio_out = 1'b1;
          if (bc_cur >= LAST_LR) begin
            bc_d = '0;
            if (ph_cur == PH_LRH) begin
              phase_d = PH_LRL;
            end else if (ph_cur == PH_C1H) begin
              phase_d = PH_C1L;
            end else begin
              phase_d = PH_C2L;
            end
          end else begin
            bc_d = bc_cur + 1'b1;
          end
        end
        PH_LRL, PH_C1L: begin
          if (bc_cur >= BC_W'(3)) begin
            bc_d = '0;
            if (ph_cur == PH_LRL) begin
              res_d.done_res = 1'b1;
              phase_d = PH_IDLE;
            end else begin
              phase_d = PH_CSW;
            end
          end else begin
            bc_d = bc_cur + 1'b1;
          end
        end
        PH_CSW: begin
          res_d.swdio_out = SWITCH_SEQ[bc_cur[3:0]];
          if (bc_cur >= BC_W'(15)) begin
            phase_d = PH_C2H;
            bc_d    = '0;
          end else begin
            bc_d = bc_cur + 1'b1;
          end
        end
        default: begin
          // second reset low clocks followed by idle clocks
          if (bc_cur >= BC_W'(7)) begin
            res_d.done_res = 1'b1;
            phase_d = PH_IDLE;
            bc_d    = '0;
          end else begin
            bc_d = bc_cur + 1'b1;
          end
        end
      endcase
      drive_d = res_d.swdio_drive;
      if (!res_d.swdio_drive) begin
        res_d.swdio_out = 1'b0;
      end
    end
    res_d.busy_res = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bc_q    <= '0;
      shift_q <= '0;
      req_q   <= '0;
      ack_q   <= '0;
      att_q   <= '0;
      rflag_q <= 1'b0;
      drive_q <= 1'b1;
      res_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      bc_q    <= bc_d;
      shift_q <= shift_d;
      req_q   <= req_d;
      ack_q   <= ack_d;
      att_q   <= att_d;
      rflag_q <= rflag_d;
      drive_q <= drive_d;
      res_q   <= res_d;
    end
  end

  assign res_o = res_q;

  a_status_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_q.status != ST_OK) |-> res_q.done_res)
    else $error("status set without done");

  a_read_data_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_q.read_data != 32'd0) |-> (res_q.done_res && res_q.status == ST_OK))
    else $error("read data outside a good read");

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.done_res |-> !res_q.busy_res)
    else $error("done while still busy");

  a_idle_tick_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_q == PH_IDLE && item_i.cmd == CMD_TICK)
      |=> (!res_q.clock_pulse && !res_q.busy_res))
    else $error("idle tick produced a clock");

  a_released_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_q.swdio_drive |-> !res_q.swdio_out)
    else $error("swdio level driven while released");

endmodule

// File: rtl/core/swd_host_transfer_engine_top.sv
// swd_host_transfer_engine_top: serial wire debug host, input register, sequencer, apb regs
// depends on swdh_pkg, swdh_apb_regs, swdh_engine
//
//   channel   direction   handshake                 payload
//   input     in          in_valid_i / in_stall_o   cmd, ap_not_dp, read_not_write,
//                                                   reg_addr, write_data, swdio_in
//   output    out         out_valid_o / out_stall_i swdio_out, swdio_drive, clock_pulse,
//                                                   busy_res, done_res, status, read_data
//   config    in          apb psel/penable/pready   wait_retry_limit at byte address 0
//
// one transaction per cycle sustained while the output is not stalled; each goes from acceptance
// to its result through the input register, then the sequencer step into the result register
// sequencer state advances only when a transaction moves into the result register
// a stalled output holds its result; the input register keeps taking until it is full
// reset is asynchronous and needs no clearing pass
module swd_host_transfer_engine_top
  import swdh_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic               ap_not_dp_i,
  input  logic               read_not_write_i,
  input  logic [1:0]         reg_addr_i,
  input  logic [31:0]        write_data_i,
  input  logic               swdio_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               swdio_out_o,
  output logic               swdio_drive_o,
  output logic               clock_pulse_o,
  output logic               busy_res_o,
  output logic               done_res_o,
  output logic [2:0]         status_o,
  output logic [31:0]        read_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic       in_valid_q, in_valid_d;
  logic       out_valid_q, out_valid_d;
  item_t      item_q;
  logic       out_free, step, load;
  logic [7:0] retry_limit;
  result_t    res;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (load) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.cmd            <= cmd_i;
      item_q.ap_not_dp      <= ap_not_dp_i;
      item_q.read_not_write <= read_not_write_i;
      item_q.reg_addr       <= reg_addr_i;
      item_q.write_data     <= write_data_i;
      item_q.swdio_in       <= swdio_in_i;
    end
  end

  swdh_apb_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .retry_limit_o (retry_limit)
  );

  swdh_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .item_i        (item_q),
    .retry_limit_i (retry_limit),
    .res_o         (res)
  );

  assign out_valid_o   = out_valid_q;
  assign swdio_out_o   = res.swdio_out;
  assign swdio_drive_o = res.swdio_drive;
  assign clock_pulse_o = res.clock_pulse;
  assign busy_res_o    = res.busy_res;
  assign done_res_o    = res.done_res;
  assign status_o      = res.status;
  assign read_data_o   = res.read_data;

endmodule
